### rtl/gcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared constants and types for the gate chain sequencer.
// ----------------------------------------------------------------------------
package gcs_pkg;

   localparam int NUM_GATES   = 5;
   localparam int QUEUE_DEPTH = 8;
   localparam int NUM_REGS    = 5;
   localparam int NUM_QUEUES  = NUM_GATES - 1;

   localparam int DEST_W  = 3;
   localparam int DWELL_W = 16;
   localparam int REG_W   = 32;
   localparam int INDEX_W = 3;
   localparam int MASK_W  = NUM_GATES;
   localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

   // open dwell in the upper half, closed dwell in the lower half
   localparam logic [REG_W-1:0] DWELL_RESET [NUM_REGS] = '{
      {16'd50,  16'd750},
      {16'd400, 16'd100},
      {16'd500, 16'd100},
      {16'd100, 16'd250},
      {16'd250, 16'd250}
   };

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic [MASK_W-1:0] open_mask;
   } rsp_type;

endpackage : gcs_pkg
`default_nettype wire

### rtl/gate_chain_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gate_chain_sequencer
// Chain of gates with dwell counters and per-gate destination queues.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_new_destination
//   rsp     | out       | rsp_valid/rsp_stall | rsp_fired_mask, rsp_open_mask
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One tick per cycle while requests are accepted: gates, counters and queues
// update in combinational logic; results are registered in the output stage.
// A two-entry output stage (result register plus skid register) keeps the
// input open while one result waits; req_stall rises only when both are full.
// Synchronous reset clears counters, gate flags, queue heads and fills and
// restores the dwell registers. csr writes are always taken.
// ----------------------------------------------------------------------------
module gate_chain_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [gcs_pkg::DEST_W-1:0]    req_new_destination,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [gcs_pkg::MASK_W-1:0]    rsp_fired_mask,
   output      logic [gcs_pkg::MASK_W-1:0]    rsp_open_mask,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [gcs_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [gcs_pkg::REG_W-1:0]     csr_wdata
);
   import gcs_pkg::*;

   logic [REG_W-1:0]   dwell_regs_ff [NUM_REGS];
   logic [DWELL_W-1:0] count_ff [NUM_GATES];
   logic [DWELL_W-1:0] count_in [NUM_GATES];
   logic [NUM_GATES-1:0] open_ff, open_in;
   logic [DEST_W-1:0]  queue_store_ff [NUM_QUEUES][QUEUE_DEPTH];
   logic [HEAD_W-1:0]  head_ff [NUM_QUEUES];
   logic [HEAD_W-1:0]  head_in [NUM_QUEUES];
   logic [FILL_W-1:0]  fill_ff [NUM_QUEUES];
   logic [FILL_W-1:0]  fill_in [NUM_QUEUES];

   logic [NUM_GATES-1:0]  fire;
   logic [NUM_QUEUES-1:0] pop_en;
   logic [NUM_QUEUES-1:0] push_req;
   logic [NUM_QUEUES-1:0] push_en;
   logic [DEST_W-1:0]     pop_data [NUM_QUEUES];
   logic [DEST_W-1:0]     push_data [NUM_QUEUES];
   logic [HEAD_W-1:0]     wr_addr [NUM_QUEUES];

   logic    accept;
   logic    out_take;
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff, result_in;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_fired_mask = out_ff.fired_mask;
   assign rsp_open_mask  = out_ff.open_mask;

   // dwell compare for every gate
   always_comb begin
      logic [DWELL_W:0]   cnt;
      logic [DWELL_W-1:0] dwell;
      for (int g = 0; g < NUM_GATES; g++) begin
         cnt = {1'b0, count_ff[g]} + {{DWELL_W{1'b0}}, 1'b1};
         if (g < NUM_REGS) begin
            dwell = open_ff[g] ? dwell_regs_ff[g][REG_W-1:DWELL_W]
                               : dwell_regs_ff[g][DWELL_W-1:0];
         end else begin
            dwell = '0;
         end
         fire[g]     = cnt >= {1'b0, dwell};
         count_in[g] = fire[g] ? '0 : cnt[DWELL_W-1:0];
      end
   end

   // queue q is popped by gate q+1 before gate q pushes into it
   always_comb begin
      logic [HEAD_W:0] sum;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         pop_en[q]   = fire[q+1] && (fill_ff[q] != '0);
         pop_data[q] = queue_store_ff[q][head_ff[q]];
      end
      open_in = open_ff;
      if (fire[0]) begin
         open_in[0] = (req_new_destination < DEST_W'(NUM_GATES)) && !open_ff[0];
      end
      for (int g = 1; g < NUM_GATES; g++) begin
         if (fire[g]) begin
            open_in[g] = pop_en[g-1] && (pop_data[g-1] != DEST_W'(g));
         end
      end
      push_req[0]  = fire[0] && open_in[0];
      push_data[0] = req_new_destination;
      for (int q = 1; q < NUM_QUEUES; q++) begin
         push_req[q]  = fire[q] && open_in[q];
         push_data[q] = pop_data[q-1];
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         push_en[q] = push_req[q] &&
                      ((fill_ff[q] - FILL_W'(pop_en[q])) < FILL_W'(QUEUE_DEPTH));
         fill_in[q] = fill_ff[q] - FILL_W'(pop_en[q]) + FILL_W'(push_en[q]);
         if (pop_en[q]) begin
            head_in[q] = (head_ff[q] == HEAD_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_ff[q] + HEAD_W'(1);
         end else begin
            head_in[q] = head_ff[q];
         end
         // head plus fill stays below twice the depth
         sum = {1'b0, head_ff[q]} + (HEAD_W+1)'(fill_ff[q]);
         if (sum >= (HEAD_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (HEAD_W+1)'(QUEUE_DEPTH);
         end
         wr_addr[q] = sum[HEAD_W-1:0];
      end
      result_in.fired_mask = fire;
      result_in.open_mask  = open_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            dwell_regs_ff[r] <= DWELL_RESET[r];
         end
      end else if (csr_valid && csr_ready) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if (csr_index == INDEX_W'(r)) begin
               dwell_regs_ff[r] <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
         for (int g = 0; g < NUM_GATES; g++) begin
            count_ff[g] <= '0;
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            fill_ff[q] <= '0;
         end
      end else if (accept) begin
         open_ff <= open_in;
         for (int g = 0; g < NUM_GATES; g++) begin
            count_ff[g] <= count_in[g];
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= head_in[q];
            fill_ff[q] <= fill_in[q];
         end
      end
   end

   // queue entries carry no reset
   always_ff @(posedge clock) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (accept && push_en[q]) begin
            queue_store_ff[q][wr_addr[q]] <= push_data[q];
         end
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= result_in;
         end else begin
            out_ff <= result_in;
         end
      end
   end

endmodule : gate_chain_sequencer
`default_nettype wire
